>>> rtl/xtd_pkg.sv
// Shared types, character codes and command encodings for the tag message deframer.
// No dependencies; imported by the datapath, the controller, the top level and the checker.
package xtd_pkg;

  // Default depth of the tag name store
  localparam int MAX_TAG_NAME_DEF = 30;

  // Message length limit register
  localparam int          MSG_LEN_W       = 16;
  localparam logic [15:0] MAX_MSG_LEN_RST = 16'hFFFF;

  // Character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;

  // Output byte source select
  localparam logic [2:0] SRC_IN   = 3'd0;
  localparam logic [2:0] SRC_LT   = 3'd1;
  localparam logic [2:0] SRC_GT   = 3'd2;
  localparam logic [2:0] SRC_MEM  = 3'd3;
  localparam logic [2:0] SRC_ZERO = 3'd4;

  // Close-tag match counter operations
  localparam logic [1:0] CMC_HOLD = 2'd0;
  localparam logic [1:0] CMC_CLR  = 2'd1;
  localparam logic [1:0] CMC_ONE  = 2'd2;
  localparam logic [1:0] CMC_INC  = 2'd3;

  // Commands from controller to datapath
  typedef struct packed {
    logic       name_clr;
    logic       name_wr;
    logic       idx_clr;
    logic       idx_inc;
    logic       mbc_load;
    logic       mbc_inc;
    logic [1:0] cmc_op;
    logic       rd_replay;
    logic       out_load;
    logic [2:0] out_src;
    logic       out_first;
    logic       out_last;
    logic       out_aband;
    logic       out_lor;
  } xtd_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_lt;
    logic is_gt;
    logic is_nul;
    logic is_start;
    logic is_name;
    logic name_full;
    logic close_hit;
    logic close_done;
    logic too_long;
    logic replay_more;
  } xtd_stat_t;

  function automatic logic is_start_letter(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           (c == CH_COLON) || (c == CH_USCORE);
  endfunction

  function automatic logic is_name_letter(input logic [7:0] c);
    return is_start_letter(c) || ((c >= 8'h30) && (c <= 8'h39)) ||
           (c == CH_DASH) || (c == CH_DOT);
  endfunction

endpackage

>>> rtl/xml_tag_message_deframer.sv
// Deframer for tag-delimited messages in a byte stream: one request per byte in hunt and body.
// A result appears in the cycle after its request; the result register frees the input side.
// Confirming an open tag holds the input while the name is replayed from the name
// store, one registered read per cycle while the result slot is free.
// Synchronous active-low reset: hunting, counters cleared, length limit 65535;
// the name store is not cleared and is always written before its contents are used.
module xml_tag_message_deframer #(
  parameter int MAX_TAG_NAME = xtd_pkg::MAX_TAG_NAME_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_abort,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_first_of_message,
  output logic        out_last_of_message,
  output logic        out_abandoned,
  output logic        out_last_of_run,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_max_message_length
);
  import xtd_pkg::*;

  xtd_cmd_t  cmd;
  xtd_stat_t stat;
  logic      cfg_wr;

  // Configuration writes are always taken
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  xtd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_abort  (in_abort),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  xtd_datapath #(
    .MAX_TAG_NAME (MAX_TAG_NAME)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_data_byte (in_data_byte),
    .cfg_wr       (cfg_wr),
    .cfg_data     (cfg_max_message_length),
    .cmd          (cmd),
    .stat         (stat),
    .out_byte     (out_byte),
    .out_first    (out_first_of_message),
    .out_last     (out_last_of_message),
    .out_aband    (out_abandoned),
    .out_lor      (out_last_of_run)
  );

endmodule

>>> rtl/xtd_datapath.sv
// Datapath of the tag message deframer: name store, counters, close-tag compare, result register.
// Depends on xtd_pkg; driven by xtd_ctrl through command and status structs.
module xtd_datapath #(
  parameter int MAX_TAG_NAME = xtd_pkg::MAX_TAG_NAME_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          in_data_byte,
  input  logic                cfg_wr,
  input  logic [15:0]         cfg_data,
  input  xtd_pkg::xtd_cmd_t   cmd,
  output xtd_pkg::xtd_stat_t  stat,
  output logic [7:0]          out_byte,
  output logic                out_first,
  output logic                out_last,
  output logic                out_aband,
  output logic                out_lor
);
  import xtd_pkg::*;

  localparam int AW    = (MAX_TAG_NAME > 1) ? $clog2(MAX_TAG_NAME) : 1;
  localparam int LEN_W = $clog2(MAX_TAG_NAME + 1);
  localparam int CMC_W = $clog2(MAX_TAG_NAME + 3);

  logic [7:0]           name_mem [MAX_TAG_NAME];
  logic [7:0]           rd_data_r;
  logic [AW-1:0]        rd_addr;

  logic [LEN_W-1:0]     len_r, len_nxt;
  logic [LEN_W-1:0]     idx_r, idx_nxt;
  logic [CMC_W-1:0]     cmc_r, cmc_nxt;
  logic [CMC_W-1:0]     cmc_m2;
  logic [CMC_W-1:0]     len_p2;
  logic [MSG_LEN_W-1:0] mbc_r, mbc_nxt;
  logic [MSG_LEN_W-1:0] max_len_r;
  logic [7:0]           exp_byte;
  logic [7:0]           out_byte_nxt;

  logic [7:0]           out_byte_r;
  logic                 out_first_r, out_last_r, out_aband_r, out_lor_r;

  // Name length and replay index
  always_comb begin
    len_nxt = len_r;
    if (cmd.name_clr) begin
      len_nxt = '0;
    end else if (cmd.name_wr) begin
      len_nxt = len_r + LEN_W'(1);
    end
    idx_nxt = idx_r;
    if (cmd.idx_clr) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + LEN_W'(1);
    end
  end

  // Close-tag match count
  always_comb begin
    case (cmd.cmc_op)
      CMC_CLR: cmc_nxt = '0;
      CMC_ONE: cmc_nxt = CMC_W'(1);
      CMC_INC: cmc_nxt = cmc_r + CMC_W'(1);
      default: cmc_nxt = cmc_r;
    endcase
  end

  // Message byte count
  always_comb begin
    mbc_nxt = mbc_r;
    if (cmd.mbc_load) begin
      mbc_nxt = MSG_LEN_W'(len_r) + MSG_LEN_W'(2);
    end else if (cmd.mbc_inc) begin
      mbc_nxt = mbc_r + MSG_LEN_W'(1);
    end
  end

  // Prefetch the name letter needed next: replay index or next close-tag letter
  assign cmc_m2  = cmc_nxt - CMC_W'(2);
  assign rd_addr = cmd.rd_replay ? idx_nxt[AW-1:0] : cmc_m2[AW-1:0];

  // Expected byte of the close tag at the current match position
  assign len_p2 = CMC_W'(len_r) + CMC_W'(2);
  always_comb begin
    if (cmc_r == CMC_W'(1)) begin
      exp_byte = CH_SLASH;
    end else if ((cmc_r >= CMC_W'(2)) && (cmc_r < len_p2)) begin
      exp_byte = rd_data_r;
    end else begin
      exp_byte = CH_GT;
    end
  end

  // Status towards the controller
  always_comb begin
    stat.is_lt       = (in_data_byte == CH_LT);
    stat.is_gt       = (in_data_byte == CH_GT);
    stat.is_nul      = (in_data_byte == CH_NUL);
    stat.is_start    = is_start_letter(in_data_byte);
    stat.is_name     = is_name_letter(in_data_byte);
    stat.name_full   = (len_r == LEN_W'(MAX_TAG_NAME));
    stat.close_hit   = (cmc_r != '0) && (in_data_byte == exp_byte);
    stat.close_done  = stat.close_hit && (cmc_r >= len_p2);
    stat.too_long    = ({1'b0, mbc_r} + 17'd1) >= {1'b0, max_len_r};
    stat.replay_more = (idx_r < len_r);
  end

  // Result byte select
  always_comb begin
    unique case (cmd.out_src)
      SRC_IN:  out_byte_nxt = in_data_byte;
      SRC_LT:  out_byte_nxt = CH_LT;
      SRC_GT:  out_byte_nxt = CH_GT;
      SRC_MEM: out_byte_nxt = rd_data_r;
      default: out_byte_nxt = CH_NUL;
    endcase
  end

  // Name store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.name_wr) begin
      name_mem[len_r[AW-1:0]] <= in_data_byte;
    end
    rd_data_r <= name_mem[rd_addr];
  end

  // Control counters and limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r     <= '0;
      idx_r     <= '0;
      cmc_r     <= '0;
      mbc_r     <= '0;
      max_len_r <= MAX_MSG_LEN_RST;
    end else begin
      len_r <= len_nxt;
      idx_r <= idx_nxt;
      cmc_r <= cmc_nxt;
      mbc_r <= mbc_nxt;
      if (cfg_wr) begin
        max_len_r <= cfg_data;
      end
    end
  end

  // Result register, loaded when the controller issues a result
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_byte_r  <= out_byte_nxt;
      out_first_r <= cmd.out_first;
      out_last_r  <= cmd.out_last;
      out_aband_r <= cmd.out_aband;
      out_lor_r   <= cmd.out_lor;
    end
  end

  assign out_byte  = out_byte_r;
  assign out_first = out_first_r;
  assign out_last  = out_last_r;
  assign out_aband = out_aband_r;
  assign out_lor   = out_lor_r;

endmodule

>>> rtl/xtd_ctrl.sv
// Controller of the tag message deframer: parse state machine, handshakes and datapath commands.
// Depends on xtd_pkg; steers xtd_datapath through command and status structs.
module xtd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_abort,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  xtd_pkg::xtd_stat_t  stat,
  output xtd_pkg::xtd_cmd_t   cmd
);
  import xtd_pkg::*;

  localparam logic [2:0] S_HUNT   = 3'd0;
  localparam logic [2:0] S_LT     = 3'd1;
  localparam logic [2:0] S_NAME   = 3'd2;
  localparam logic [2:0] S_BODY   = 3'd3;
  localparam logic [2:0] S_REPLAY = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;
  logic       acc;

  // The result slot is free when empty or being drained this cycle
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = slot_free && (state_r != S_REPLAY);
  assign acc       = in_valid && in_ready;

  // Next state and commands
  always_comb begin
    cmd         = '0;
    cmd.cmc_op  = CMC_HOLD;
    cmd.out_src = SRC_ZERO;
    state_nxt   = state_r;
    if (acc && in_abort) begin
      // Drop any partial message; only a message in its body reports it
      if (state_r == S_BODY) begin
        cmd.out_load  = 1'b1;
        cmd.out_aband = 1'b1;
        cmd.out_lor   = 1'b1;
      end
      state_nxt = S_HUNT;
    end else if (acc && (state_r == S_BODY)) begin
      if (stat.is_nul) begin
        cmd.out_load  = 1'b1;
        cmd.out_aband = 1'b1;
        cmd.out_lor   = 1'b1;
        state_nxt     = S_HUNT;
      end else if (stat.close_done) begin
        cmd.out_load = 1'b1;
        cmd.out_src  = SRC_IN;
        cmd.out_last = 1'b1;
        cmd.out_lor  = 1'b1;
        cmd.cmc_op   = CMC_CLR;
        state_nxt    = S_HUNT;
      end else if (stat.too_long) begin
        cmd.out_load  = 1'b1;
        cmd.out_aband = 1'b1;
        cmd.out_lor   = 1'b1;
        cmd.cmc_op    = CMC_CLR;
        state_nxt     = S_HUNT;
      end else begin
        // Pass the body byte and advance the close-tag match
        cmd.out_load = 1'b1;
        cmd.out_src  = SRC_IN;
        cmd.out_lor  = 1'b1;
        cmd.mbc_inc  = 1'b1;
        if (stat.close_hit) begin
          cmd.cmc_op = CMC_INC;
        end else if (stat.is_lt) begin
          cmd.cmc_op = CMC_ONE;
        end else begin
          cmd.cmc_op = CMC_CLR;
        end
      end
    end else if (acc && stat.is_lt) begin
      // Restart the candidate open tag
      cmd.name_clr = 1'b1;
      state_nxt    = S_LT;
    end else if (acc) begin
      unique case (state_r)
        S_HUNT: begin
          state_nxt = S_HUNT;
        end
        S_LT: begin
          if (stat.is_start) begin
            cmd.name_wr = 1'b1;
            state_nxt   = S_NAME;
          end else begin
            state_nxt = S_HUNT;
          end
        end
        S_NAME: begin
          if (stat.is_name && !stat.name_full) begin
            cmd.name_wr = 1'b1;
          end else if (stat.is_gt) begin
            // Open tag confirmed: emit '<' now, replay the name next
            cmd.out_load  = 1'b1;
            cmd.out_src   = SRC_LT;
            cmd.out_first = 1'b1;
            cmd.idx_clr   = 1'b1;
            cmd.mbc_load  = 1'b1;
            cmd.cmc_op    = CMC_CLR;
            state_nxt     = S_REPLAY;
          end else begin
            state_nxt = S_HUNT;
          end
        end
        default: begin
          state_nxt = S_HUNT;
        end
      endcase
    end else if ((state_r == S_REPLAY) && slot_free) begin
      cmd.out_load = 1'b1;
      if (stat.replay_more) begin
        cmd.out_src = SRC_MEM;
        cmd.idx_inc = 1'b1;
      end else begin
        cmd.out_src = SRC_GT;
        cmd.out_lor = 1'b1;
        state_nxt   = S_BODY;
      end
    end
    cmd.rd_replay = (state_nxt == S_REPLAY);
  end

  // Result slot occupancy
  assign out_valid_nxt = cmd.out_load || (out_valid_r && !out_ready);
  assign out_valid     = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_HUNT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> rtl/xtd_checker.sv
// Port-level checks for the tag message deframer, bound to the top level.
// Depends on xtd_pkg for character codes.
module xtd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte,
  input logic        out_first_of_message,
  input logic        out_last_of_message,
  input logic        out_abandoned,
  input logic        out_last_of_run
);
  import xtd_pkg::*;

  // Hold a stalled result unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
      $stable(out_abandoned) && $stable(out_last_of_run))
    else $error("stalled result changed");

  // An abandon carries no byte and closes its run
  a_aband: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_abandoned |-> (out_byte == CH_NUL) && !out_first_of_message &&
      !out_last_of_message && out_last_of_run)
    else $error("malformed abandon result");

  // The message end is the close tag's '>' and the last of its run
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_of_message |-> (out_byte == CH_GT) && out_last_of_run &&
      !out_first_of_message)
    else $error("malformed message end");

  // The message start is '<' and is always followed by the rest of the open tag
  a_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_first_of_message |-> (out_byte == CH_LT) && !out_last_of_run)
    else $error("malformed message start");

endmodule

bind xml_tag_message_deframer xtd_checker u_xtd_checker (.*);

>>> tb/sv/xml_tag_message_deframer_tb.sv
`timescale 1ns / 1ps
// Testbench for xml_tag_message_deframer: feeds byte streams of tagged messages, noise and
// broken tags, predicts each delivered byte and abandon marker, and checks every result.
// Depends on rtl/xtd_pkg.sv, rtl/xml_tag_message_deframer.sv, rtl/xtd_ctrl.sv and rtl/xtd_datapath.sv.
module xml_tag_message_deframer_tb;
  import xtd_pkg::*;

  localparam int NAME_MAX     = MAX_TAG_NAME_DEF;
  localparam int QUIET_CYCLES = 8;
  localparam int STALL_CYCLES = 300;
  localparam int TAIL_CYCLES  = 40;

  typedef enum logic [1:0] {
    MODE_HUNT,
    MODE_AFTER_LT,
    MODE_IN_NAME,
    MODE_IN_BODY
  } parse_mode_t;

  typedef struct packed {
    logic [7:0] byte_val;
    logic       first_flag;
    logic       last_flag;
    logic       aband_flag;
    logic       run_end;
  } frame_out_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_abort;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_byte;
  logic        out_first_of_message;
  logic        out_last_of_message;
  logic        out_abandoned;
  logic        out_last_of_run;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_max_message_length;

  // Predicted deframer state
  parse_mode_t mdl_mode;
  logic [7:0]  mdl_name [NAME_MAX];
  int unsigned mdl_name_len;
  int unsigned mdl_match;
  int unsigned mdl_count;
  int unsigned mdl_limit;

  frame_out_t  frame_bytes_due[$];
  int          fail_count;
  int          useful_items;
  int          snd_idle_pct;
  int          rcv_idle_pct;
  int          stall_asked;
  int          stall_served;

  xml_tag_message_deframer u_top (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_data_byte           (in_data_byte),
    .in_abort               (in_abort),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_byte               (out_byte),
    .out_first_of_message   (out_first_of_message),
    .out_last_of_message    (out_last_of_message),
    .out_abandoned          (out_abandoned),
    .out_last_of_run        (out_last_of_run),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_max_message_length (cfg_max_message_length)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Safety net against a hung handshake
  initial begin
    #20_000_000;
    $display("** xml_tag_message_deframer: FAILED **");
    $finish;
  end

  // Character classes of the tag grammar
  function automatic bit tag_start_char(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
           c == CH_COLON || c == CH_USCORE;
  endfunction

  function automatic bit tag_name_char(input logic [7:0] c);
    return tag_start_char(c) || (c >= 8'h30 && c <= 8'h39) || c == CH_DASH || c == CH_DOT;
  endfunction

  function automatic logic [7:0] rand_start_char();
    int unsigned r;
    r = $urandom_range(0, 53);
    if (r < 26) return 8'(32'h61 + r);
    if (r < 52) return 8'(32'h41 + r - 26);
    return (r == 52) ? CH_COLON : CH_USCORE;
  endfunction

  function automatic logic [7:0] rand_name_char();
    int unsigned r;
    r = $urandom_range(0, 65);
    if (r < 54) return rand_start_char();
    if (r < 64) return 8'(32'h30 + r - 54);
    return (r == 64) ? CH_DASH : CH_DOT;
  endfunction

  // Byte k of the close tag built from the stored name
  function automatic logic [7:0] close_tag_byte(input int unsigned k);
    if (k == 0) return CH_LT;
    if (k == 1) return CH_SLASH;
    if (k - 2 < mdl_name_len) return mdl_name[k - 2];
    return CH_GT;
  endfunction

  function automatic frame_out_t make_result(input logic [7:0] b, input logic f,
                                             input logic l, input logic a);
    frame_out_t r;
    r.byte_val   = b;
    r.first_flag = f;
    r.last_flag  = l;
    r.aband_flag = a;
    r.run_end    = 1'b0;
    return r;
  endfunction

  // Advance the predicted state by one request and queue the results it causes
  task automatic deframe_request(input logic [7:0] c, input logic ab);
    frame_out_t  run[$];
    frame_out_t  r;
    parse_mode_t prev;
    bit          closed;
    prev   = mdl_mode;
    closed = 1'b0;
    if (ab) begin
      if (mdl_mode == MODE_IN_BODY) run.push_back(make_result(8'h00, 1'b0, 1'b0, 1'b1));
      mdl_mode = MODE_HUNT;
    end else if (mdl_mode == MODE_IN_BODY) begin
      if (c == CH_NUL) begin
        run.push_back(make_result(8'h00, 1'b0, 1'b0, 1'b1));
        mdl_mode = MODE_HUNT;
      end else begin
        // track progress through the close tag
        if (mdl_match > 0 && c == close_tag_byte(mdl_match)) begin
          mdl_match++;
          closed = (mdl_match >= mdl_name_len + 3);
        end else if (c == CH_LT) begin
          mdl_match = 1;
        end else begin
          mdl_match = 0;
        end
        if (closed) begin
          run.push_back(make_result(c, 1'b0, 1'b1, 1'b0));
          mdl_mode  = MODE_HUNT;
          mdl_match = 0;
        end else if (mdl_count + 1 >= mdl_limit) begin
          run.push_back(make_result(8'h00, 1'b0, 1'b0, 1'b1));
          mdl_mode  = MODE_HUNT;
          mdl_match = 0;
        end else begin
          mdl_count++;
          run.push_back(make_result(c, 1'b0, 1'b0, 1'b0));
        end
      end
    end else if (c == CH_LT) begin
      mdl_mode     = MODE_AFTER_LT;
      mdl_name_len = 0;
    end else if (mdl_mode == MODE_AFTER_LT) begin
      if (tag_start_char(c)) begin
        mdl_name[0]  = c;
        mdl_name_len = 1;
        mdl_mode     = MODE_IN_NAME;
      end else begin
        mdl_mode = MODE_HUNT;
      end
    end else if (mdl_mode == MODE_IN_NAME) begin
      if (tag_name_char(c)) begin
        if (mdl_name_len < NAME_MAX) begin
          mdl_name[mdl_name_len] = c;
          mdl_name_len++;
        end else begin
          mdl_mode = MODE_HUNT;
        end
      end else if (c == CH_GT) begin
        // replay the confirmed open tag
        run.push_back(make_result(CH_LT, 1'b1, 1'b0, 1'b0));
        for (int i = 0; i < mdl_name_len; i++)
          run.push_back(make_result(mdl_name[i], 1'b0, 1'b0, 1'b0));
        run.push_back(make_result(CH_GT, 1'b0, 1'b0, 1'b0));
        mdl_count = mdl_name_len + 2;
        mdl_match = 0;
        mdl_mode  = MODE_IN_BODY;
      end else begin
        mdl_mode = MODE_HUNT;
      end
    end
    if (run.size() > 0) begin
      r = run.pop_back();
      r.run_end = 1'b1;
      run.push_back(r);
    end
    foreach (run[i]) frame_bytes_due.push_back(run[i]);
    if (run.size() > 0 || prev != MODE_HUNT || mdl_mode != MODE_HUNT) useful_items++;
  endtask

  // Offer one byte, hold it until accepted, then predict
  task automatic send_byte(input logic [7:0] b, input logic ab);
    if ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_abort     <= ab;
    do @(posedge clk); while (!in_ready);
    deframe_request(b, ab);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  // Drop valid, let every expected result arrive, then allow the block to settle
  task automatic wait_until_quiet();
    in_valid <= 1'b0;
    while (frame_bytes_due.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_length_limit(input logic [15:0] value);
    wait_until_quiet();
    cfg_valid              <= 1'b1;
    cfg_max_message_length <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mdl_limit = 32'(value);
  endtask

  // One message with a random name and body, ended in one of several ways
  task automatic send_random_message();
    logic [7:0]  name[$];
    int unsigned nlen;
    int unsigned blen;
    int unsigned r;
    int unsigned k;
    nlen = ($urandom_range(9) == 0) ? $urandom_range(1, NAME_MAX) : $urandom_range(1, 6);
    name.push_back(rand_start_char());
    for (int i = 1; i < nlen; i++) name.push_back(rand_name_char());
    send_byte(CH_LT, 1'b0);
    foreach (name[i]) send_byte(name[i], 1'b0);
    send_byte(CH_GT, 1'b0);
    blen = ($urandom_range(19) == 0) ? $urandom_range(30, 90) : $urandom_range(0, 16);
    for (int i = 0; i < blen; i++) begin
      r = $urandom_range(99);
      if (r < 70)      send_byte(8'($urandom_range(1, 255)), 1'b0);
      else if (r < 80) send_byte(CH_LT, 1'b0);
      else if (r < 88) send_byte(CH_SLASH, 1'b0);
      else             send_byte(name[$urandom_range(0, nlen - 1)], 1'b0);
    end
    r = $urandom_range(99);
    if (r < 80) begin
      // sometimes a false start of the close tag first
      if ($urandom_range(4) == 0) begin
        k = $urandom_range(0, nlen - 1);
        send_byte(CH_LT, 1'b0);
        send_byte(CH_SLASH, 1'b0);
        for (int i = 0; i < k; i++) send_byte(name[i], 1'b0);
        send_byte(8'($urandom_range(1, 255)), 1'b0);
      end
      send_byte(CH_LT, 1'b0);
      send_byte(CH_SLASH, 1'b0);
      foreach (name[i]) send_byte(name[i], 1'b0);
      send_byte(CH_GT, 1'b0);
    end else if (r < 88) begin
      send_byte(8'($urandom_range(0, 255)), 1'b1);
    end else if (r < 95) begin
      send_byte(CH_NUL, 1'b0);
    end
  endtask

  // A candidate tag that breaks before its '>'
  task automatic send_broken_tag();
    int unsigned n;
    send_byte(CH_LT, 1'b0);
    case ($urandom_range(3))
      0: send_byte(8'(32'h30 + $urandom_range(0, 9)), 1'b0);
      1: send_byte(CH_LT, 1'b0);
      default: begin
        n = $urandom_range(0, 5);
        send_byte(rand_start_char(), 1'b0);
        for (int i = 0; i < n; i++) send_byte(rand_name_char(), 1'b0);
        send_byte(($urandom_range(1) == 0) ? CH_NUL : 8'h20, $urandom_range(7) == 0);
      end
    endcase
  endtask

  task automatic test_directed_cases();
    write_length_limit(16'hFFFF);
    // noise and an abort while hunting
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    // '<' restarts the candidate, then body extremes and a partial close
    send_text("<<a>");
    send_byte(8'hFF, 1'b0);
    send_byte(8'h01, 1'b0);
    send_text("</b</a>");
    // broken candidates: bad start, bad name letter, NUL in name
    send_text("<9<a ");
    send_text("<a");
    send_byte(CH_NUL, 1'b0);
    // NUL in body, abort in body
    send_text("<_:>");
    send_byte(CH_NUL, 1'b0);
    send_text("<Z.-0>");
    send_byte(CH_GT, 1'b1);
  endtask

  task automatic test_name_limits();
    string nm;
    nm = "";
    nm = {nm, string'(rand_start_char())};
    for (int i = 1; i < NAME_MAX; i++) nm = {nm, string'(rand_name_char())};
    // longest name that still confirms
    send_text({"<", nm, ">x</", nm, ">"});
    // one letter more drops the candidate; the '>' is then noise
    send_text({"<", nm, "q>"});
  endtask

  task automatic test_length_limit();
    write_length_limit(16'd8);
    send_text("<ab>xyzw");
    send_text("<a>x</a>");
    send_text("<a></a>");
    send_text("<abcdefghij>x");
    send_text("<abcdefghij></abcdefghij>");
    write_length_limit(16'($urandom_range(8, 64)));
    for (int i = 0; i < 2; i++) send_random_message();
  endtask

  task automatic test_random_traffic(input int n);
    int start;
    int unsigned r;
    start = useful_items;
    while (useful_items - start < n) begin
      r = $urandom_range(99);
      if (r < 75) begin
        send_random_message();
      end else if (r < 88) begin
        repeat ($urandom_range(1, 6))
          send_byte(8'($urandom_range(0, 255)), $urandom_range(9) == 0);
      end else begin
        send_broken_tag();
      end
    end
  endtask

  // Hold the receiver off while the sender keeps offering
  task automatic test_output_stall();
    stall_asked++;
    repeat (2) send_random_message();
  endtask

  // Result receiver: random stalls, plus long hold-offs on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_served != stall_asked) begin
        out_ready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
        stall_served++;
      end else begin
        out_ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // Compare each accepted result with the oldest expected one
  always @(posedge clk) begin : check_results
    frame_out_t due;
    if (rst_n && out_valid && out_ready) begin
      if (frame_bytes_due.size() == 0) begin
        $error("unexpected result: out_byte %0h abandoned %0b", out_byte, out_abandoned);
        fail_count++;
      end else begin
        due = frame_bytes_due.pop_front();
        if (out_byte !== due.byte_val) begin
          $error("out_byte: expected %0h, actual %0h", due.byte_val, out_byte);
          fail_count++;
        end
        if (out_first_of_message !== due.first_flag) begin
          $error("first_of_message: expected %0b, actual %0b", due.first_flag,
                 out_first_of_message);
          fail_count++;
        end
        if (out_last_of_message !== due.last_flag) begin
          $error("last_of_message: expected %0b, actual %0b", due.last_flag,
                 out_last_of_message);
          fail_count++;
        end
        if (out_abandoned !== due.aband_flag) begin
          $error("abandoned: expected %0b, actual %0b", due.aband_flag, out_abandoned);
          fail_count++;
        end
        if (out_last_of_run !== due.run_end) begin
          $error("last_of_run: expected %0b, actual %0b", due.run_end, out_last_of_run);
          fail_count++;
        end
      end
    end
  end

  // Test sequence
  initial begin : main_sequence
    int wait_n;
    rst_n                  = 1'b0;
    in_valid               = 1'b0;
    in_data_byte           = 8'h00;
    in_abort               = 1'b0;
    cfg_valid              = 1'b0;
    cfg_max_message_length = MAX_MSG_LEN_RST;
    fail_count             = 0;
    useful_items           = 0;
    stall_asked            = 0;
    stall_served           = 0;
    snd_idle_pct           = 34;
    rcv_idle_pct           = 71;
    mdl_mode               = MODE_HUNT;
    mdl_name_len           = 0;
    mdl_match              = 0;
    mdl_count              = 0;
    mdl_limit              = 32'(MAX_MSG_LEN_RST);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_name_limits();
    test_length_limit();
    test_random_traffic(10);

    wait_until_quiet();
    snd_idle_pct = 71;
    rcv_idle_pct = 34;
    write_length_limit(16'($urandom_range(20, 200)));
    test_random_traffic(30);
    test_output_stall();

    wait_until_quiet();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    write_length_limit(16'hFFFF);
    test_random_traffic(30);
    write_length_limit(16'($urandom_range(8, 16)));
    test_random_traffic(20);

    // drain with a bound, then settle
    in_valid <= 1'b0;
    for (wait_n = 0; wait_n < 50000 && frame_bytes_due.size() != 0; wait_n++)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (frame_bytes_due.size() != 0)
      $error("%0d expected results never arrived", frame_bytes_due.size());
    if (fail_count == 0 && frame_bytes_due.size() == 0) begin
      $display("** xml_tag_message_deframer: PASSED **");
    end else begin
      $display("** xml_tag_message_deframer: FAILED **");
    end
    $finish;
  end

endmodule
